// ===== rtl/tct_pkg.sv =====
`default_nettype none
package tct_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] KIND_KEYWORD = 2'd0;
	localparam logic [1:0] KIND_IDENT   = 2'd1;
	localparam logic [1:0] KIND_CONST   = 2'd2;
	localparam logic [1:0] KIND_OP      = 2'd3;

	typedef struct packed {
		logic has_op;
		logic has_num;
		logic word_kw;
		logic has_word;
	} tok_flags_t;

	localparam int FLAGS_W = $bits(tok_flags_t);

endpackage
`default_nettype wire

// ===== rtl/tct_front.sv =====
`default_nettype none
module tct_front #(
	parameter int unsigned     MAX_TOKEN_LEN = 255,
	parameter longint unsigned POSITION_MAX  = 65535
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [7:0]                 char_code,
	output tct_pkg::tok_flags_t             ev_flags,
	output logic [15:0]                     ev_row,
	output logic [$clog2(POSITION_MAX + 64'd1)-1:0] ev_col,
	output logic [$clog2(MAX_TOKEN_LEN + 1)-1:0]    ev_wlen,
	output logic [$clog2(MAX_TOKEN_LEN + 1)-1:0]    ev_nlen,
	output logic [7:0]                      ev_op,
	output logic                            push
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int POS_W = $clog2(POSITION_MAX + 64'd1);

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;

	function automatic logic [7:0] kw_int_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h69;
			3'd1:    ch = 8'h6E;
			3'd2:    ch = 8'h74;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] kw_return_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h72;
			3'd1:    ch = 8'h65;
			3'd2:    ch = 8'h74;
			3'd3:    ch = 8'h75;
			3'd4:    ch = 8'h72;
			3'd5:    ch = 8'h6E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	logic [LEN_W-1:0] wlen_q, nlen_q, wlen_n, nlen_n, wlen_inc, nlen_inc;
	logic             int_q, ret_q, int_n, ret_n, esc_q, esc_n;
	logic [POS_W-1:0] row_q, col_q, row_n, col_n, row_inc, col_inc;
	logic             is_letter, is_digit, is_oper;
	logic             flush_w, flush_n, has_op, int_ok, ret_ok;

	assign is_letter = (char_code >= 8'h61 && char_code <= 8'h7A)
		|| (char_code >= 8'h41 && char_code <= 8'h5A);
	assign is_digit  = (char_code >= 8'h30 && char_code <= 8'h39) || char_code == CH_DOT;
	assign is_oper   = char_code == CH_LPAREN || char_code == CH_RPAREN
		|| char_code == CH_LBRACE || char_code == CH_RBRACE || char_code == CH_SEMI;

	assign col_inc  = (col_q < POS_W'(POSITION_MAX)) ? col_q + POS_W'(1) : col_q;
	assign row_inc  = (row_q < POS_W'(POSITION_MAX)) ? row_q + POS_W'(1) : row_q;
	assign wlen_inc = (wlen_q < LEN_W'(MAX_TOKEN_LEN)) ? wlen_q + LEN_W'(1) : wlen_q;
	assign nlen_inc = (nlen_q < LEN_W'(MAX_TOKEN_LEN)) ? nlen_q + LEN_W'(1) : nlen_q;

	assign int_ok = int_q && wlen_q < LEN_W'(3) && kw_int_char(wlen_q[2:0]) == char_code;
	assign ret_ok = ret_q && wlen_q < LEN_W'(6) && kw_return_char(wlen_q[2:0]) == char_code;

	always_comb begin
		wlen_n  = wlen_q;
		nlen_n  = nlen_q;
		int_n   = int_q;
		ret_n   = ret_q;
		esc_n   = esc_q;
		row_n   = row_q;
		col_n   = col_inc;
		flush_w = 1'b0;
		flush_n = 1'b0;
		has_op  = 1'b0;
		priority if (is_letter) begin
			if (!esc_q) begin
				wlen_n = wlen_inc;
				int_n  = int_ok;
				ret_n  = ret_ok;
			end else begin
				esc_n = 1'b0;
				if (char_code == CH_N) begin
					flush_w = 1'b1;
					flush_n = 1'b1;
					row_n   = row_inc;
					col_n   = '0;
				end
			end
		end else if (is_digit) begin
			flush_w = 1'b1;
			nlen_n  = nlen_inc;
		end else if (is_oper) begin
			flush_w = 1'b1;
			flush_n = 1'b1;
			has_op  = 1'b1;
		end else if (char_code == CH_BSLASH) begin
			esc_n = 1'b1;
		end else begin
			flush_w = 1'b1;
			flush_n = 1'b1;
		end
		if (flush_w) begin
			wlen_n = '0;
			int_n  = 1'b1;
			ret_n  = 1'b1;
		end
		if (flush_n) begin
			nlen_n = '0;
		end
	end

	always_comb begin
		ev_flags.has_word = flush_w && wlen_q != '0;
		ev_flags.word_kw  = (wlen_q == LEN_W'(3) && int_q) || (wlen_q == LEN_W'(6) && ret_q);
		ev_flags.has_num  = flush_n && nlen_q != '0;
		ev_flags.has_op   = has_op;
	end

	assign ev_row  = 16'(row_q);
	assign ev_col  = col_inc;
	assign ev_wlen = wlen_q;
	assign ev_nlen = nlen_q;
	assign ev_op   = char_code;
	assign push    = accept && (ev_flags.has_word || ev_flags.has_num || ev_flags.has_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
			nlen_q <= '0;
			int_q  <= 1'b1;
			ret_q  <= 1'b1;
			esc_q  <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			wlen_q <= wlen_n;
			nlen_q <= nlen_n;
			int_q  <= int_n;
			ret_q  <= ret_n;
			esc_q  <= esc_n;
			row_q  <= row_n;
			col_q  <= col_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tct_queue.sv =====
`default_nettype none
module tct_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  not_empty
);

	logic [WIDTH-1:0]               mem_q [tct_pkg::QUEUE_DEPTH];
	logic [tct_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [tct_pkg::QCNT_W-1:0]     count_q;

	assign full      = count_q == tct_pkg::QCNT_W'(tct_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tct_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tct_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tct_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tct_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tct_back.sv =====
`default_nettype none
module tct_back #(
	parameter int unsigned     MAX_TOKEN_LEN = 255,
	parameter longint unsigned POSITION_MAX  = 65535
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    q_valid,
	input  wire tct_pkg::tok_flags_t                     ev_flags,
	input  wire logic [15:0]                             ev_row,
	input  wire logic [$clog2(POSITION_MAX + 64'd1)-1:0] ev_col,
	input  wire logic [$clog2(MAX_TOKEN_LEN + 1)-1:0]    ev_wlen,
	input  wire logic [$clog2(MAX_TOKEN_LEN + 1)-1:0]    ev_nlen,
	input  wire logic [7:0]                              ev_op,
	output logic                                         q_pop,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic [1:0]                                   token_kind,
	output logic [15:0]                                  token_row,
	output logic [15:0]                                  token_col,
	output logic [7:0]                                   token_length,
	output logic [7:0]                                   operator_code,
	output logic                                         last_token
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int POS_W = $clog2(POSITION_MAX + 64'd1);
	localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

	logic [2:0]       done_q, pend, sel, rest;
	logic             is_last, load, valid_q;
	logic [1:0]       kind_c, kind_q;
	logic [LEN_W-1:0] len_c, sub_c;
	logic [7:0]       op_c, op_q, len_q;
	logic [CMP_W-1:0] col_x, sub_x, start_c;
	logic [15:0]      row_q, col_q;
	logic             last_q;

	assign pend    = {ev_flags.has_op, ev_flags.has_num, ev_flags.has_word} & ~done_q;
	assign sel     = pend & (~pend + 3'd1);
	assign rest    = pend & ~sel;
	assign is_last = rest == 3'd0;
	assign load    = q_valid && (!valid_q || out_ready);
	assign q_pop   = load && is_last;

	always_comb begin
		priority if (sel[0]) begin
			kind_c = ev_flags.word_kw ? tct_pkg::KIND_KEYWORD : tct_pkg::KIND_IDENT;
			len_c  = ev_wlen;
			sub_c  = ev_wlen;
			op_c   = 8'h00;
		end else if (sel[1]) begin
			kind_c = tct_pkg::KIND_CONST;
			len_c  = ev_nlen;
			sub_c  = ev_nlen;
			op_c   = 8'h00;
		end else begin
			kind_c = tct_pkg::KIND_OP;
			len_c  = LEN_W'(1);
			sub_c  = '0;
			op_c   = ev_op;
		end
	end

	assign col_x   = CMP_W'(ev_col);
	assign sub_x   = CMP_W'(sub_c);
	assign start_c = (col_x >= sub_x) ? col_x - sub_x : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				done_q  <= is_last ? 3'd0 : (done_q | sel);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_c;
			row_q  <= ev_row;
			col_q  <= 16'(start_c);
			len_q  <= 8'(len_c);
			op_q   <= op_c;
			last_q <= is_last;
		end
	end

	assign out_valid     = valid_q;
	assign token_kind    = kind_q;
	assign token_row     = row_q;
	assign token_col     = col_q;
	assign token_length  = len_q;
	assign operator_code = op_q;
	assign last_token    = last_q;

endmodule
`default_nettype wire

// ===== rtl/tiny_c_tokenizer_top.sv =====
// Channel   Dir  Fields
// s_axis    in   tdata[7:0] char_code
// m_axis    out  tdata: kind, row, col, length, operator; tlast marks last token of a char
//
// One character is taken per cycle while the token queue has a free slot.
// A character yielding tokens leaves one queue entry; tokens go out one per cycle
// while m_axis_tready is high, so a character with three tokens gives three transfers.
// A character's tokens pass through a queue entry and then the output register.
// arst_n clears lexer state, queue pointers and output valid; no clearing pass.
// A stalled m_axis fills the four-entry queue, then s_axis_tready drops.
`default_nettype none
module tiny_c_tokenizer_top #(
	parameter int unsigned     MAX_TOKEN_LEN = 255,
	parameter longint unsigned POSITION_MAX  = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [1:0] token_kind, [17:2] token_row, [33:18] token_col,
	// [41:34] token_length, [49:42] operator_code, [55:50] zero
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tlast   // last_token
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int POS_W = $clog2(POSITION_MAX + 64'd1);
	localparam int ENT_W = tct_pkg::FLAGS_W + 16 + POS_W + 2 * LEN_W + 8;

	tct_pkg::tok_flags_t f_flags, b_flags;
	logic [15:0]         f_row, b_row;
	logic [POS_W-1:0]    f_col, b_col;
	logic [LEN_W-1:0]    f_wlen, f_nlen, b_wlen, b_nlen;
	logic [7:0]          f_op, b_op;
	logic                q_push, q_pop, q_full, q_valid, accept;
	logic [ENT_W-1:0]    q_wdata, q_rdata;
	logic [1:0]          token_kind;
	logic [15:0]         token_row, token_col;
	logic [7:0]          token_length, operator_code;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	tct_front #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.POSITION_MAX (POSITION_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.char_code(s_axis_tdata),
		.ev_flags (f_flags),
		.ev_row   (f_row),
		.ev_col   (f_col),
		.ev_wlen  (f_wlen),
		.ev_nlen  (f_nlen),
		.ev_op    (f_op),
		.push     (q_push)
	);

	assign q_wdata = {f_flags, f_row, f_col, f_wlen, f_nlen, f_op};

	tct_queue #(
		.WIDTH(ENT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.full     (q_full),
		.not_empty(q_valid)
	);

	assign {b_flags, b_row, b_col, b_wlen, b_nlen, b_op} = q_rdata;

	tct_back #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.POSITION_MAX (POSITION_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.ev_flags     (b_flags),
		.ev_row       (b_row),
		.ev_col       (b_col),
		.ev_wlen      (b_wlen),
		.ev_nlen      (b_nlen),
		.ev_op        (b_op),
		.q_pop        (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.token_kind   (token_kind),
		.token_row    (token_row),
		.token_col    (token_col),
		.token_length (token_length),
		.operator_code(operator_code),
		.last_token   (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, operator_code, token_length, token_col, token_row, token_kind};

	a_pop_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_axis_tvalid && m_axis_tlast)
		else $error("queue pop without a last token on the output");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> q_valid)
		else $error("non-last token sent with no entry left in the queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> q_full)
		else $error("queue accepted an entry while full");

endmodule
`default_nettype wire
